// File: hdl/keyboard_rollover_key_buffer_defines.svh
// Assertion macros shared by the key buffer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef KEYBOARD_ROLLOVER_KEY_BUFFER_DEFINES_SVH
`define KEYBOARD_ROLLOVER_KEY_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KBUF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KBUF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kbuf_pkg.sv
package kbuf_pkg;

    // Fixed field widths of the request and result.
    localparam int KEY_W       = 8;
    localparam int COUNT_W     = 3;
    localparam int SHOWN_SLOTS = 6;

    // Default list depth for six-key rollover.
    localparam int DEFAULT_NUM_SLOTS = 6;

    // Request codes; the fourth code is unused and only clears report_out.
    typedef enum logic [1:0] {
        REQ_PRESS   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_SEND    = 2'd2
    } req_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } kbuf_cmd_t;

endpackage

// File: hdl/keyboard_rollover_key_buffer.sv
// Pressed-key list for a six-key-rollover keyboard report.
// Request channel: drive req_type and keycode with start high; the request
// transfers at the rising edge where start is high and busy is low.
// req_type: press adds the key unless listed (a full list drops it but sets
// dirty), release removes the first match and closes the gap, send clears
// dirty and flags report_out. The unused code only clears report_out.
// Result channel: done is high for exactly one cycle, the cycle right after
// the request transfer; slot0..slot5, key_count, dirty and report_out are
// valid in that cycle and show the list after the request. The receiver
// cannot stall, so the result transfers at the edge ending that cycle.
// The block takes no new request while its result is shown: the match and
// shift over all slots finish in the request cycle, and the controller holds
// busy during the result cycle.
// Reset clears the list, the count, dirty and report_out at once; the block
// takes a request in the first cycle after reset is released.
module keyboard_rollover_key_buffer
    import kbuf_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [KEY_W-1:0]   keycode,
    output logic               done,
    output logic [KEY_W-1:0]   slot0,
    output logic [KEY_W-1:0]   slot1,
    output logic [KEY_W-1:0]   slot2,
    output logic [KEY_W-1:0]   slot3,
    output logic [KEY_W-1:0]   slot4,
    output logic [KEY_W-1:0]   slot5,
    output logic [COUNT_W-1:0] key_count,
    output logic               dirty,
    output logic               report_out
);

    kbuf_cmd_t                         cmd;
    logic [SHOWN_SLOTS-1:0][KEY_W-1:0] slot_view;

    // Controller: request handshake and result strobe.
    kbuf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Datapath: key list, count and changed mark.
    kbuf_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .keycode    (keycode),
        .slot_view  (slot_view),
        .key_count  (key_count),
        .dirty      (dirty),
        .report_out (report_out)
    );

    // Spread the slot view over the result ports.
    assign slot0 = slot_view[0];
    assign slot1 = slot_view[1];
    assign slot2 = slot_view[2];
    assign slot3 = slot_view[3];
    assign slot4 = slot_view[4];
    assign slot5 = slot_view[5];

endmodule

// File: hdl/kbuf_ctrl.sv
`include "keyboard_rollover_key_buffer_defines.svh"

module kbuf_ctrl
    import kbuf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output kbuf_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd.exec   = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                busy       = 1'b1;
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Every accepted request yields exactly one result strobe in the next cycle.
    `KBUF_ASSERT_NEXT(a_exec_then_done, cmd.exec, done, "request without result strobe")
    `KBUF_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `KBUF_ASSERT_SAME(a_no_exec_busy, busy, !cmd.exec, "request executed while busy")

endmodule

// File: hdl/kbuf_dp.sv
`include "keyboard_rollover_key_buffer_defines.svh"

module kbuf_dp
    import kbuf_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  kbuf_cmd_t                         cmd,
    input  logic [1:0]                        req_type,
    input  logic [KEY_W-1:0]                  keycode,
    output logic [SHOWN_SLOTS-1:0][KEY_W-1:0] slot_view,
    output logic [COUNT_W-1:0]                key_count,
    output logic                              dirty,
    output logic                              report_out
);

    localparam int CW = $clog2(NUM_SLOTS + 1);

    logic [NUM_SLOTS-1:0][KEY_W-1:0] slots_reg;
    logic [NUM_SLOTS-1:0][KEY_W-1:0] slots_next;
    logic [NUM_SLOTS-1:0][KEY_W-1:0] slots_shifted;
    logic [CW-1:0]                   fill_reg;
    logic [CW-1:0]                   fill_next;
    logic                            mark_reg;
    logic                            mark_next;
    logic                            report_reg;
    logic                            report_next;
    logic [NUM_SLOTS-1:0]            match;
    logic [NUM_SLOTS-1:0]            from_match;
    logic                            hit;
    logic                            full;
    logic                            tail_zero;
    logic [CW+COUNT_W-1:0]           fill_wide;

    // Compare the key against every listed slot side by side.
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            match[i] = (CW'(i) < fill_reg) && (slots_reg[i] == keycode);
        end
    end

    // Mark the first match and every slot above it; those slots move down.
    always_comb
    begin
        from_match[0] = match[0];
        for (int i = 1; i < NUM_SLOTS; i++)
        begin
            from_match[i] = from_match[i-1] | match[i];
        end
    end

    assign hit           = |match;
    assign full          = (fill_reg == CW'(NUM_SLOTS));
    assign slots_shifted = slots_reg >> KEY_W;

    // Next list state for the accepted request.
    always_comb
    begin
        slots_next  = slots_reg;
        fill_next   = fill_reg;
        mark_next   = mark_reg;
        report_next = report_reg;
        if (cmd.exec)
        begin
            report_next = 1'b0;
            case (req_type)
                REQ_PRESS:
                begin
                    // A duplicate press changes neither list nor mark; a press on a full list only marks.
                    if (!hit)
                    begin
                        if (!full)
                        begin
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                if (CW'(i) == fill_reg)
                                begin
                                    slots_next[i] = keycode;
                                end
                            end
                            fill_next = fill_reg + CW'(1);
                        end
                        mark_next = 1'b1;
                    end
                end
                REQ_RELEASE:
                begin
                    // Slots above the list end hold zero, so the shift also clears the freed slot.
                    if (hit)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (from_match[i])
                            begin
                                slots_next[i] = slots_shifted[i];
                            end
                        end
                        fill_next = fill_reg - CW'(1);
                        mark_next = 1'b1;
                    end
                end
                REQ_SEND:
                begin
                    mark_next   = 1'b0;
                    report_next = 1'b1;
                end
                default:
                begin
                    mark_next = mark_reg;
                end
            endcase
        end
    end

    // List, count and changed mark registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg  <= '0;
            fill_reg   <= '0;
            mark_reg   <= 1'b0;
            report_reg <= 1'b0;
        end
        else
        begin
            slots_reg  <= slots_next;
            fill_reg   <= fill_next;
            mark_reg   <= mark_next;
            report_reg <= report_next;
        end
    end

    // Result view: slots past the list depth read zero.
    for (genvar j = 0; j < SHOWN_SLOTS; j++)
    begin : g_view
        if (j < NUM_SLOTS)
        begin : g_live
            assign slot_view[j] = slots_reg[j];
        end
        else
        begin : g_zero
            assign slot_view[j] = '0;
        end
    end

    assign fill_wide  = {{COUNT_W{1'b0}}, fill_reg};
    assign key_count  = fill_wide[COUNT_W-1:0];
    assign dirty      = mark_reg;
    assign report_out = report_reg;

    // Every slot at or above the fill count must hold zero.
    always_comb
    begin
        tail_zero = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if ((CW'(i) >= fill_reg) && (slots_reg[i] != '0))
            begin
                tail_zero = 1'b0;
            end
        end
    end

    `KBUF_ASSERT_SAME(a_fill_range, 1'b1, fill_reg <= CW'(NUM_SLOTS), "fill count past depth")
    `KBUF_ASSERT_SAME(a_tail_zero, 1'b1, tail_zero, "stale key above list end")
    `KBUF_ASSERT_NEXT(a_send_clears, cmd.exec && (req_type == REQ_SEND),
        !mark_reg && report_reg, "send did not clear changed mark")
    `KBUF_ASSERT_NEXT(a_idle_hold, !cmd.exec, $stable(fill_reg) && $stable(mark_reg),
        "list state changed without a request")

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import kbuf_pkg::*;

    // The fourth request code is not a member of req_t and must change only report_out.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         LIST_DEPTH = DEFAULT_NUM_SLOTS;

    // One result as seen on the result ports.
    typedef struct packed {
        logic [SHOWN_SLOTS-1:0][KEY_W-1:0] slots;
        logic [COUNT_W-1:0]                key_count;
        logic                              dirty;
        logic                              report_out;
    } key_report_t;

    // Tracks the pressed-key list and holds the reports still to come.
    class key_list_scoreboard;
        logic [KEY_W-1:0] held_keys [LIST_DEPTH];
        int unsigned      held_count;
        bit               changed;
        key_report_t      pending_reports [$];
        int unsigned      error_count;

        function new();
            foreach (held_keys[i])
            begin
                held_keys[i] = '0;
            end
            held_count  = 0;
            changed     = 1'b0;
            error_count = 0;
        endfunction

        // Applies one transferred request to the list and queues its report.
        function void note_request(logic [1:0] req, logic [KEY_W-1:0] code);
            key_report_t report;
            int          hit;
            bit          sent;
            hit  = -1;
            sent = 1'b0;
            for (int i = 0; i < int'(held_count); i++)
            begin
                if (hit < 0 && held_keys[i] == code)
                begin
                    hit = i;
                end
            end
            case (req)
                REQ_PRESS:
                begin
                    // A duplicate press leaves the list and the mark alone.
                    if (hit < 0)
                    begin
                        if (held_count < LIST_DEPTH)
                        begin
                            held_keys[held_count] = code;
                            held_count++;
                        end
                        changed = 1'b1;
                    end
                end
                REQ_RELEASE:
                begin
                    // Close the gap and clear the freed last slot.
                    if (hit >= 0)
                    begin
                        for (int j = hit + 1; j < int'(held_count); j++)
                        begin
                            held_keys[j - 1] = held_keys[j];
                        end
                        held_keys[held_count - 1] = '0;
                        held_count--;
                        changed = 1'b1;
                    end
                end
                REQ_SEND:
                begin
                    changed = 1'b0;
                    sent    = 1'b1;
                end
                default:
                begin
                end
            endcase
            for (int j = 0; j < SHOWN_SLOTS; j++)
            begin
                report.slots[j] = (j < LIST_DEPTH) ? held_keys[j] : '0;
            end
            report.key_count  = held_count[COUNT_W-1:0];
            report.dirty      = changed;
            report.report_out = sent;
            pending_reports.push_back(report);
        endfunction

        // Prints one line per mismatch, up to a cap, and counts every one.
        task report_mismatch(string what);
            if (error_count < 30)
            begin
                $display("mismatch at %0t ns: %s", $time, what);
            end
            error_count++;
        endtask

        // Compares one transferred result against the oldest queued report.
        task check_result(key_report_t seen);
            key_report_t want;
            if (pending_reports.size() == 0)
            begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = pending_reports.pop_front();
            for (int j = 0; j < SHOWN_SLOTS; j++)
            begin
                if (seen.slots[j] !== want.slots[j])
                begin
                    report_mismatch($sformatf("slot%0d got %h want %h",
                                              j, seen.slots[j], want.slots[j]));
                end
            end
            if (seen.key_count !== want.key_count)
            begin
                report_mismatch($sformatf("key_count got %0d want %0d",
                                          seen.key_count, want.key_count));
            end
            if (seen.dirty !== want.dirty)
            begin
                report_mismatch($sformatf("dirty got %b want %b", seen.dirty, want.dirty));
            end
            if (seen.report_out !== want.report_out)
            begin
                report_mismatch($sformatf("report_out got %b want %b",
                                          seen.report_out, want.report_out));
            end
        endtask

        task check_drained();
            if (pending_reports.size() != 0)
            begin
                report_mismatch($sformatf("%0d results never arrived",
                                          pending_reports.size()));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         req_type = REQ_PRESS;
    logic [KEY_W-1:0]   keycode = '0;
    logic               busy;
    logic               done;
    logic [KEY_W-1:0]   slot0;
    logic [KEY_W-1:0]   slot1;
    logic [KEY_W-1:0]   slot2;
    logic [KEY_W-1:0]   slot3;
    logic [KEY_W-1:0]   slot4;
    logic [KEY_W-1:0]   slot5;
    logic [COUNT_W-1:0] key_count;
    logic               dirty;
    logic               report_out;

    key_list_scoreboard key_book = new();

    keyboard_rollover_key_buffer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .keycode    (keycode),
        .done       (done),
        .slot0      (slot0),
        .slot1      (slot1),
        .slot2      (slot2),
        .slot3      (slot3),
        .slot4      (slot4),
        .slot5      (slot5),
        .key_count  (key_count),
        .dirty      (dirty),
        .report_out (report_out)
    );

    // Free-running clock.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    // Watch both channels; the result of a transfer comes no earlier than
    // the next edge, so results are checked before new requests are noted.
    always @(posedge clk)
    begin
        key_report_t seen;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                seen.slots      = {slot5, slot4, slot3, slot2, slot1, slot0};
                seen.key_count  = key_count;
                seen.dirty      = dirty;
                seen.report_out = report_out;
                key_book.check_result(seen);
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                key_book.note_request(req_type, keycode);
            end
        end
    end

    // Presents one request and holds it until it transfers, then maybe idles.
    task issue_request(input logic [1:0] req, input logic [KEY_W-1:0] code,
                       input int unsigned idle_pct);
        start    <= 1'b1;
        req_type <= req;
        keycode  <= code;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Mostly press and release traffic over a small set of codes, so the list
    // fills, overflows and empties; the rest are sends, stray codes and the
    // unused request.
    task run_random(input int unsigned count, input int unsigned idle_pct);
        logic [KEY_W-1:0] key_pool [8];
        logic [1:0]       req;
        logic [KEY_W-1:0] code;
        int unsigned      pick;
        int unsigned      src;
        foreach (key_pool[i])
        begin
            key_pool[i] = $urandom_range(255);
        end
        for (int n = 0; n < int'(count); n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                req = REQ_PRESS;
            else if (pick < 80)
                req = REQ_RELEASE;
            else if (pick < 95)
                req = REQ_SEND;
            else
                req = REQ_UNUSED;
            src = $urandom_range(99);
            if (req == REQ_RELEASE && src < 50 && key_book.held_count > 0)
                code = key_book.held_keys[$urandom_range(key_book.held_count - 1)];
            else if (src < 80)
                code = key_pool[$urandom_range(7)];
            else
                code = $urandom_range(255);
            issue_request(req, code, idle_pct);
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, code zero and all-ones, duplicates, overflow
        // with the mark set, sends, releases at the head, middle and tail, unlisted
        // release and the unused request code.
        issue_request(REQ_SEND, 8'h00, 19);
        issue_request(REQ_RELEASE, 8'h00, 19);
        issue_request(REQ_PRESS, 8'h00, 19);
        issue_request(REQ_PRESS, 8'hFF, 19);
        issue_request(REQ_PRESS, 8'hFF, 19);
        issue_request(REQ_PRESS, 8'h01, 19);
        issue_request(REQ_PRESS, 8'h02, 19);
        issue_request(REQ_PRESS, 8'h03, 19);
        issue_request(REQ_PRESS, 8'h04, 19);
        issue_request(REQ_SEND, 8'hFF, 19);
        issue_request(REQ_PRESS, 8'h55, 19);
        issue_request(REQ_SEND, 8'h00, 19);
        issue_request(REQ_PRESS, 8'hAA, 19);
        issue_request(REQ_SEND, 8'h00, 19);
        issue_request(REQ_PRESS, 8'hFF, 19);
        issue_request(REQ_RELEASE, 8'h01, 19);
        issue_request(REQ_RELEASE, 8'h00, 19);
        issue_request(REQ_RELEASE, 8'h04, 19);
        issue_request(REQ_RELEASE, 8'h77, 19);
        issue_request(REQ_UNUSED, 8'hFF, 19);
        issue_request(REQ_UNUSED, 8'h02, 19);
        issue_request(REQ_RELEASE, 8'hFF, 19);
        issue_request(REQ_RELEASE, 8'h02, 19);
        issue_request(REQ_RELEASE, 8'h03, 19);
        issue_request(REQ_SEND, 8'h00, 19);

        // Random phases: light sender idling, heavy idling, then back to back.
        run_random(400, 19);
        run_random(400, 62);
        run_random(400, 0);
        start <= 1'b0;

        // Let the last results come back.
        for (int n = 0; n < 50 && key_book.pending_reports.size() != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        key_book.check_drained();

        if (key_book.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/kbuf_pkg.sv
hdl/kbuf_ctrl.sv
hdl/kbuf_dp.sv
hdl/keyboard_rollover_key_buffer.sv
test/testbench.sv
